>>> src/four_level_alarm_monitor_defines.svh
// Assertion macros shared by the alarm monitor RTL.
`ifndef FOUR_LEVEL_ALARM_MONITOR_DEFINES_SVH
`define FOUR_LEVEL_ALARM_MONITOR_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define FLAM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// A consequence that must hold in the cycle after its trigger.
`define FLAM_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("next-cycle check violated");

// A consequence that must hold in the same clock as its trigger.
`define FLAM_ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("same-cycle check violated");

`endif

>>> src/flam_pkg.sv
// Package with the constants and types of the four-level alarm monitor.
`timescale 1ns / 1ps

package flam_pkg;

    // Number of supervised levels: low alarm, low warn, high warn, high alarm.
    localparam int NUM_LEVELS = 4;

    // Default width of the on-delay counters.
    localparam int DELAY_WIDTH_DEFAULT = 16;

    // Width of one packed delay field in the delay register.
    localparam int DELAY_FIELD_WIDTH = 16;

    // Multiplier that turns the held value into percent units.
    localparam int PERCENT_SCALE = 100;

    // Levels below this index are low-side checks (at or below).
    localparam int NUM_LOW_LEVELS = 2;

    // Register reset values.
    localparam logic signed [31:0] VALUE_MIN_RESET = 32'sd0;
    localparam logic signed [31:0] VALUE_MAX_RESET = 32'sd6553600;
    localparam logic [63:0]        DELAYS_RESET    = 64'h00C8_00C8_00C8_00C8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_VALUE_MIN        = 3'd0,
        REG_VALUE_MAX        = 3'd1,
        REG_LEVEL_LOW_ALARM  = 3'd2,
        REG_LEVEL_LOW_WARN   = 3'd3,
        REG_LEVEL_HIGH_WARN  = 3'd4,
        REG_LEVEL_HIGH_ALARM = 3'd5,
        REG_DELAYS_PACKED    = 3'd6
    } cfg_reg_t;

    // Input word kinds carried in tuser.
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

endpackage

>>> src/four_level_alarm_monitor.sv
// Top level of the four-level alarm monitor with on-delay timers.
//
// The monitor takes one input word per clock and returns one result word for each: the
// word passes an input register and then a single compare stage into the result
// register, so back-to-back words flow at full rate while the result side keeps up.
// A sample word (tuser low) clamps tdata to the configured bounds and holds it; a tick
// word (tuser high) compares the held value, scaled by one hundred, against each level
// times the range, and steps the four on-delay counters. The level thresholds are
// products of configuration only and are registered from the configuration registers,
// so a configuration write reaches them before any word accepted after that write is
// evaluated. Every result carries the held value and the four alarm and warning flags.
`timescale 1ns / 1ps

`include "four_level_alarm_monitor_defines.svh"

module four_level_alarm_monitor
    import flam_pkg::*;
#(
    parameter int DELAY_WIDTH = DELAY_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [31:0] sample_value
    input  logic [31:0] s_axis_tdata,
    // tuser: [0] cmd
    input  logic        s_axis_tuser,

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [31:0] held_value_out, [32] low_alarm, [33] low_warn,
    //        [34] high_warn, [35] high_alarm, [39:36] zero
    output logic [39:0] m_axis_tdata
);

    localparam int FIELD_USED = (DELAY_WIDTH < DELAY_FIELD_WIDTH) ? DELAY_WIDTH
                                                                  : DELAY_FIELD_WIDTH;
    localparam int LIM_WIDTH  = 48;
    localparam int CMP_WIDTH  = 50;

    // Configuration registers.
    logic signed [31:0] value_min_reg;
    logic signed [31:0] value_max_reg;
    logic [15:0]        level_reg [NUM_LEVELS];
    logic [63:0]        delays_reg;

    // Registered thresholds derived from configuration.
    logic [LIM_WIDTH-1:0] lim_reg [NUM_LEVELS];
    logic                 range_zero_reg;

    // Input stage.
    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic signed [31:0] in_sample_reg;

    // Monitor state.
    logic signed [31:0]     held_reg;
    logic signed [31:0]     held_next;
    logic [DELAY_WIDTH-1:0] cnt_reg  [NUM_LEVELS];
    logic [DELAY_WIDTH-1:0] cnt_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0]  cond_reg;
    logic [NUM_LEVELS-1:0]  cond_next;
    logic [NUM_LEVELS-1:0]  flag_next;
    logic [DELAY_WIDTH-1:0] delay    [NUM_LEVELS];

    // Result stage.
    logic                  out_valid_reg;
    logic signed [31:0]    out_held_reg;
    logic [NUM_LEVELS-1:0] out_flags_reg;

    // Handshake and stage control.
    logic               out_advance;
    logic               step;
    logic signed [31:0] cfg_value32;
    logic [31:0]        range_wide;
    logic signed [38:0] scaled;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign step          = in_valid_reg && out_advance;
    assign cfg_value32   = $signed(cfg_data[31:0]);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_flags_reg, out_held_reg};

    // Configuration writes; the bounds are kept in order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_min_reg <= VALUE_MIN_RESET;
            value_max_reg <= VALUE_MAX_RESET;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                level_reg[i] <= '0;
            end
            delays_reg <= DELAYS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VALUE_MIN:
                begin
                    value_min_reg <= (cfg_value32 < value_max_reg) ? cfg_value32
                                                                   : value_max_reg;
                end
                REG_VALUE_MAX:
                begin
                    value_max_reg <= (cfg_value32 > value_min_reg) ? cfg_value32
                                                                   : value_min_reg;
                end
                REG_LEVEL_LOW_ALARM:  level_reg[0] <= cfg_data[15:0];
                REG_LEVEL_LOW_WARN:   level_reg[1] <= cfg_data[15:0];
                REG_LEVEL_HIGH_WARN:  level_reg[2] <= cfg_data[15:0];
                REG_LEVEL_HIGH_ALARM: level_reg[3] <= cfg_data[15:0];
                REG_DELAYS_PACKED:    delays_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Thresholds: each level times the range, one multiplier per level.
    // The bounds are ordered, so the difference always fits 32 unsigned bits.
    assign range_wide = $unsigned(value_max_reg - value_min_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_zero_reg <= 1'b0;
        end
        else
        begin
            range_zero_reg <= (value_max_reg == value_min_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            lim_reg[i] <= LIM_WIDTH'(level_reg[i]) * LIM_WIDTH'(range_wide[31:0]);
        end
    end

    // Delays masked to the counter width.
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            delay[i] = DELAY_WIDTH'(delays_reg[DELAY_FIELD_WIDTH*i +: FIELD_USED]);
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg    <= s_axis_tuser;
            in_sample_reg <= $signed(s_axis_tdata);
        end
    end

    // Clamp, compare and on-delay update for the word in the input register.
    assign scaled = 39'(held_reg) * 39'(PERCENT_SCALE);

    always_comb
    begin
        logic signed [CMP_WIDTH-1:0] lhs;
        logic signed [CMP_WIDTH-1:0] rhs;
        logic                        c;
        lhs       = CMP_WIDTH'(scaled);
        rhs       = '0;
        c         = 1'b0;
        held_next = held_reg;
        cond_next = cond_reg;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (in_cmd_reg == CMD_SAMPLE)
        begin
            if (in_sample_reg < value_min_reg)
            begin
                held_next = value_min_reg;
            end
            else if (in_sample_reg > value_max_reg)
            begin
                held_next = value_max_reg;
            end
            else
            begin
                held_next = in_sample_reg;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                rhs = $signed({2'b00, lim_reg[i]});
                if (range_zero_reg)
                begin
                    c = 1'b0;
                end
                else if (i < NUM_LOW_LEVELS)
                begin
                    c = (lhs <= rhs);
                end
                else
                begin
                    c = (lhs >= rhs);
                end
                cond_next[i] = c;
                if (!c)
                begin
                    cnt_next[i] = '0;
                end
                else if (cnt_reg[i] < delay[i])
                begin
                    cnt_next[i] = cnt_reg[i] + 1'b1;
                end
                else
                begin
                    cnt_next[i] = delay[i];
                end
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            flag_next[i] = cond_next[i] && (cnt_next[i] >= delay[i]);
        end
    end

    // Monitor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            cond_reg <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            held_reg <= held_next;
            cond_reg <= cond_next;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_held_reg  <= held_next;
            out_flags_reg <= flag_next;
        end
    end

    // The bounds stay ordered whatever is written.
    `FLAM_ASSERT_ALWAYS(a_bounds_ordered, value_min_reg <= value_max_reg)

    // A clamped sample lies within the bounds in force when it was taken.
    `FLAM_ASSERT_NEXT(a_held_in_bounds, step && (in_cmd_reg == CMD_SAMPLE),
        (held_reg >= $past(value_min_reg)) && (held_reg <= $past(value_max_reg)))

    // A tick over a zero range clears every flag.
    `FLAM_ASSERT_NEXT(a_zero_range_clears, step && (in_cmd_reg == CMD_TICK) && range_zero_reg,
        out_flags_reg == '0)

    // Counters and conditions move only on ticks.
    `FLAM_ASSERT_NEXT(a_state_on_tick_only, !(step && (in_cmd_reg == CMD_TICK)),
        $stable(cond_reg) && $stable(cnt_reg[0]) && $stable(cnt_reg[3]))

    // An empty result stage never holds back the input.
    `FLAM_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, s_axis_tready)

endmodule
